// File: src/cet_pkg.sv
// shared constants and types for the counter time extension block
package cet_pkg;

    localparam int CNT_W   = 64;
    localparam int SMP_W   = 32;
    localparam int CFG_W   = 32;
    localparam int US_W    = 20;
    localparam int MUL_W   = SMP_W + US_W;
    localparam int PROD_W  = CNT_W + US_W;
    localparam int IDX_W   = 2;

    localparam logic [US_W-1:0] US_PER_SECOND = 20'd1000000;

    localparam logic [IDX_W-1:0] REG_COUNTER_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_WRAP_PERIOD  = 2'd1;
    localparam logic [IDX_W-1:0] REG_COUNTER_FREQ = 2'd2;

    localparam logic             MODE_NARROW = 1'b0;
    localparam logic             FUNC_READ   = 1'b1;

    localparam logic [CFG_W-1:0] WRAP_PERIOD_RST  = 32'd1000;
    localparam logic [CFG_W-1:0] COUNTER_FREQ_RST = 32'd1000000;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: src/counter_extend_timestamp.sv
// top level: counter wrap extension, sequencer, shared multiplier and divider
// a maintain item passes the wrap check and sum states before the next item is taken
// a read item runs wrap, sum, both multiply halves, add and the divider, then raises o_valid
// one item at a time; a new item is taken once the previous result is registered
// a zero frequency makes a read item skip the multiply and divide states and raise o_valid
// synchronous active-low reset restores register defaults and clears the count state
module counter_extend_timestamp
    import cet_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_func,
    input  logic [CNT_W-1:0] i_counter_sample,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CNT_W-1:0] o_time_cycles,
    output logic [CNT_W-1:0] o_time_us
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRAP   = 3'd1;
    localparam logic [2:0] S_SUM    = 3'd2;
    localparam logic [2:0] S_MLO    = 3'd3;
    localparam logic [2:0] S_MHI    = 3'd4;
    localparam logic [2:0] S_MADD   = 3'd5;
    localparam logic [2:0] S_DSTART = 3'd6;
    localparam logic [2:0] S_DWAIT  = 3'd7;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic              r_out_pend;

    logic              r_mode;
    logic [CFG_W-1:0]  r_wrap;
    logic [CFG_W-1:0]  r_freq;
    logic [CNT_W-1:0]  r_high;
    logic [SMP_W-1:0]  r_last;

    logic              r_func;
    logic [CNT_W-1:0]  r_sample;
    logic [CNT_W-1:0]  r_count;
    logic [PROD_W-1:0] r_prod;
    logic [CNT_W-1:0]  r_us;

    logic              r_out_valid;
    logic [CNT_W-1:0]  r_out_cycles;
    logic [CNT_W-1:0]  r_out_us;

    logic [SMP_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_p;
    logic              div_start;
    t_div_stat         div_stat;
    logic [CNT_W-1:0]  div_quot;
    logic              in_take;
    logic              out_load;
    logic [SMP_W-1:0]  cur;

    assign cur       = r_sample[SMP_W-1:0];
    assign in_take   = i_valid && (r_state == S_IDLE) && !r_out_pend;
    assign out_load  = r_out_pend && (!r_out_valid || !i_stall);
    assign div_start = (r_state == S_DSTART);
    assign mul_a     = (r_state == S_MHI) ? r_count[CNT_W-1:SMP_W] : r_count[SMP_W-1:0];

    cet_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .o_p   (mul_p)
    );

    cet_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_freq),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NARROW;
            r_wrap <= WRAP_PERIOD_RST;
            r_freq <= COUNTER_FREQ_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COUNTER_MODE: r_mode <= i_cfg_data[0];
                REG_WRAP_PERIOD:  r_wrap <= i_cfg_data;
                REG_COUNTER_FREQ: r_freq <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_take) n_state = S_WRAP;
            S_WRAP:   n_state = S_SUM;
            S_SUM: begin
                if (r_func != FUNC_READ || r_freq == '0) n_state = S_IDLE;
                else n_state = S_MLO;
            end
            S_MLO:    n_state = S_MHI;
            S_MHI:    n_state = S_MADD;
            S_MADD:   n_state = S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT:  if (div_stat.done) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            r_high      <= '0;
            r_last      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_WRAP && r_mode == MODE_NARROW) begin
                if (cur < r_last) r_high <= r_high + CNT_W'(r_wrap);
                r_last <= cur;
            end
            if ((r_state == S_SUM && r_func == FUNC_READ && r_freq == '0)
                || (r_state == S_DWAIT && div_stat.done)) begin
                r_out_pend <= 1'b1;
            end else if (out_load) begin
                r_out_pend <= 1'b0;
            end
            if (out_load) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    // item payload and arithmetic
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func   <= i_func;
            r_sample <= i_counter_sample;
        end
        case (r_state)
            S_SUM: begin
                r_count <= (r_mode == MODE_NARROW) ? (r_high + CNT_W'(cur)) : r_sample;
                r_us    <= '1;
            end
            S_MHI:   r_prod <= PROD_W'(mul_p);
            S_MADD:  r_prod <= r_prod + {mul_p, {SMP_W{1'b0}}};
            S_DWAIT: if (div_stat.done) r_us <= div_quot;
            default: ;
        endcase
        if (out_load) begin
            r_out_cycles <= r_count;
            r_out_us     <= r_us;
        end
    end

    assign o_stall       = (r_state != S_IDLE) || r_out_pend;
    assign o_valid       = r_out_valid;
    assign o_time_cycles = r_out_cycles;
    assign o_time_us     = r_out_us;

    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> r_state == S_DWAIT)
        else $error("divider finished outside wait state");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DSTART |=> div_stat.busy)
        else $error("divider did not start");

    a_take_to_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_state == S_WRAP)
        else $error("accepted item did not enter wrap check");

    a_last_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRAP && r_mode == MODE_NARROW) |=> r_last == $past(cur))
        else $error("narrow sample not kept");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> $stable(r_out_us) && $stable(r_out_cycles))
        else $error("stalled result overwritten");

endmodule

// File: src/cet_mul.sv
// shared multiplier: 32-bit operand times one million, registered product
module cet_mul
    import cet_pkg::*;
(
    input  logic             i_clk,
    input  logic [SMP_W-1:0] i_a,
    output logic [MUL_W-1:0] o_p
);

    logic [MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_W'(i_a) * MUL_W'(US_PER_SECOND);
    end

    assign o_p = r_p;

endmodule

// File: src/cet_div.sv
// bit-serial restoring divider, one quotient bit per cycle, low 64 quotient bits out
module cet_div
    import cet_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [CFG_W-1:0]  i_divisor,
    output t_div_stat         o_stat,
    output logic [CNT_W-1:0]  o_quot
);

    localparam int STEP_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] r_dvd;
    logic [CFG_W-1:0]  r_div;
    logic [CFG_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [CFG_W:0]    trial;
    logic              qbit;
    logic [CFG_W:0]    diff;

    always_comb begin
        trial = {r_rem, r_dvd[PROD_W-1]};
        qbit  = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[PROD_W-2:0], 1'b0};
            r_rem <= qbit ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
            r_quo <= {r_quo[CNT_W-2:0], qbit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

endmodule
